>>> hdl/ssw_pkg.sv
// shared constants, types and helpers for the sliding window subarray sum finder
package ssw_pkg;

    localparam int WINDOW_DEPTH = 1024;
    localparam int ELEMENT_BITS = 16;
    localparam int INDEX_BITS   = 16;
    localparam int TARGET_BITS  = 32;
    localparam int SUM_BITS     = TARGET_BITS + 1;
    localparam int ADDR_BITS    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int LEN_BITS     = ADDR_BITS + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DROP,
        ST_PUSH,
        ST_CHECK,
        ST_SHRINK
    } state_t;

    typedef struct packed {
        logic                  found;
        logic [INDEX_BITS-1:0] start_index;
        logic [INDEX_BITS-1:0] end_index;
        logic                  window_overflow;
    } result_t;

    // ring slot after the given one
    function automatic logic [ADDR_BITS-1:0] ring_inc(input logic [ADDR_BITS-1:0] slot);
        logic [ADDR_BITS-1:0] nxt;
        if (slot == ADDR_BITS'(WINDOW_DEPTH - 1))
            nxt = '0;
        else
            nxt = slot + 1'b1;
        return nxt;
    endfunction

endpackage

>>> hdl/ssw_ram.sv
// generic single write port ram with registered read
module ssw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/ssw_core.sv
// window ring, running sum and the sequencer around the shared add/subtract unit
module ssw_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                elem_valid,
    output logic                                elem_ready,
    input  logic [ssw_pkg::ELEMENT_BITS-1:0]    element_value,
    input  logic                                is_last,
    input  logic [ssw_pkg::TARGET_BITS-1:0]     target,
    input  logic                                res_free,
    output logic                                res_load,
    output ssw_pkg::result_t                    res
);

    ssw_pkg::state_t state_reg, state_next;

    logic [ssw_pkg::ELEMENT_BITS-1:0] v_reg, v_next;
    logic                             last_reg, last_next;
    logic [ssw_pkg::SUM_BITS-1:0]     sum_reg, sum_next;
    logic [ssw_pkg::ADDR_BITS-1:0]    head_reg, head_next;
    logic [ssw_pkg::LEN_BITS-1:0]     len_reg, len_next;
    logic [ssw_pkg::INDEX_BITS-1:0]   start_reg, start_next;
    logic [ssw_pkg::INDEX_BITS-1:0]   next_pos_reg, next_pos_next;
    logic [ssw_pkg::INDEX_BITS-1:0]   pos_reg, pos_next;
    logic                             match_reg, match_next;
    logic                             ovf_reg, ovf_next;

    logic                             ram_we;
    logic [ssw_pkg::ELEMENT_BITS-1:0] ram_wdata;
    logic [ssw_pkg::ELEMENT_BITS-1:0] ram_rdata;
    logic [ssw_pkg::ADDR_BITS-1:0]    tail_addr;
    logic [ssw_pkg::LEN_BITS-1:0]     tail_wide;

    logic                             alu_sub;
    logic [ssw_pkg::ELEMENT_BITS-1:0] alu_b;
    logic [ssw_pkg::SUM_BITS-1:0]     alu_y;

    logic [ssw_pkg::SUM_BITS-1:0]     target_ext;
    logic                             sum_eq;
    logic                             shrink_need;
    logic                             clear_req;

    // slot just past the newest element
    assign tail_wide = ssw_pkg::LEN_BITS'(head_reg) + len_reg;
    assign tail_addr = (tail_wide >= ssw_pkg::LEN_BITS'(ssw_pkg::WINDOW_DEPTH))
                       ? ssw_pkg::ADDR_BITS'(tail_wide - ssw_pkg::LEN_BITS'(ssw_pkg::WINDOW_DEPTH))
                       : ssw_pkg::ADDR_BITS'(tail_wide);

    ssw_ram #(
        .WIDTH (ssw_pkg::ELEMENT_BITS),
        .DEPTH (ssw_pkg::WINDOW_DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_addr),
        .wdata (ram_wdata),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    // the one shared adder: adds the pushed word or takes away the oldest one
    assign alu_sub = (state_reg == ssw_pkg::ST_DROP) || (state_reg == ssw_pkg::ST_SHRINK);
    assign alu_b   = alu_sub ? ram_rdata
                   : ((state_reg == ssw_pkg::ST_IDLE) ? element_value : v_reg);
    assign alu_y   = alu_sub ? (sum_reg - ssw_pkg::SUM_BITS'(alu_b))
                             : (sum_reg + ssw_pkg::SUM_BITS'(alu_b));

    assign target_ext  = ssw_pkg::SUM_BITS'(target);
    assign sum_eq      = (sum_reg == target_ext);
    assign shrink_need = (sum_reg > target_ext) && (len_reg > ssw_pkg::LEN_BITS'(1));

    assign ram_wdata = (state_reg == ssw_pkg::ST_IDLE) ? element_value : v_reg;

    always_comb
    begin
        res.found           = sum_eq;
        res.start_index     = sum_eq ? start_reg : '0;
        res.end_index       = sum_eq ? pos_reg : '0;
        res.window_overflow = ovf_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ssw_pkg::ST_IDLE;
            sum_reg      <= '0;
            head_reg     <= '0;
            len_reg      <= '0;
            start_reg    <= '0;
            next_pos_reg <= '0;
            match_reg    <= 1'b0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            sum_reg      <= sum_next;
            head_reg     <= head_next;
            len_reg      <= len_next;
            start_reg    <= start_next;
            next_pos_reg <= next_pos_next;
            match_reg    <= match_next;
            ovf_reg      <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        last_reg <= last_next;
        pos_reg  <= pos_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        v_next        = v_reg;
        last_next     = last_reg;
        sum_next      = sum_reg;
        head_next     = head_reg;
        len_next      = len_reg;
        start_next    = start_reg;
        next_pos_next = next_pos_reg;
        pos_next      = pos_reg;
        match_next    = match_reg;
        ovf_next      = ovf_reg;
        ram_we        = 1'b0;
        elem_ready    = 1'b0;
        res_load      = 1'b0;
        clear_req     = 1'b0;

        unique case (state_reg)
            ssw_pkg::ST_IDLE:
            begin
                elem_ready = 1'b1;
                if (elem_valid)
                begin
                    v_next    = element_value;
                    last_next = is_last;
                    if (match_reg)
                    begin
                        // rest of a matched array is skipped
                        clear_req = is_last;
                    end
                    else if (len_reg == ssw_pkg::LEN_BITS'(ssw_pkg::WINDOW_DEPTH))
                    begin
                        state_next = ssw_pkg::ST_DROP;
                    end
                    else
                    begin
                        ram_we        = 1'b1;
                        sum_next      = alu_y;
                        len_next      = len_reg + 1'b1;
                        pos_next      = next_pos_reg;
                        next_pos_next = next_pos_reg + 1'b1;
                        state_next    = ssw_pkg::ST_CHECK;
                    end
                end
            end

            ssw_pkg::ST_DROP:
            begin
                sum_next   = alu_y;
                head_next  = ssw_pkg::ring_inc(head_reg);
                start_next = start_reg + 1'b1;
                len_next   = len_reg - 1'b1;
                ovf_next   = 1'b1;
                state_next = ssw_pkg::ST_PUSH;
            end

            ssw_pkg::ST_PUSH:
            begin
                ram_we        = 1'b1;
                sum_next      = alu_y;
                len_next      = len_reg + 1'b1;
                pos_next      = next_pos_reg;
                next_pos_next = next_pos_reg + 1'b1;
                state_next    = ssw_pkg::ST_CHECK;
            end

            ssw_pkg::ST_CHECK:
            begin
                if (shrink_need)
                begin
                    state_next = ssw_pkg::ST_SHRINK;
                end
                else if (sum_eq || last_reg)
                begin
                    // hold here until the result register can take the word
                    if (res_free)
                    begin
                        res_load   = 1'b1;
                        state_next = ssw_pkg::ST_IDLE;
                        if (last_reg)
                            clear_req = 1'b1;
                        else
                            match_next = 1'b1;
                    end
                end
                else
                begin
                    state_next = ssw_pkg::ST_IDLE;
                end
            end

            ssw_pkg::ST_SHRINK:
            begin
                sum_next   = alu_y;
                head_next  = ssw_pkg::ring_inc(head_reg);
                start_next = start_reg + 1'b1;
                len_next   = len_reg - 1'b1;
                state_next = ssw_pkg::ST_CHECK;
            end

            default:
            begin
                state_next = ssw_pkg::ST_IDLE;
            end
        endcase

        if (clear_req)
        begin
            sum_next      = '0;
            head_next     = '0;
            len_next      = '0;
            start_next    = '0;
            next_pos_next = '0;
            match_next    = 1'b0;
            ovf_next      = 1'b0;
        end
    end

    a_shrink_keeps_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ssw_pkg::ST_SHRINK) |-> (len_reg > ssw_pkg::LEN_BITS'(1)))
        else $error("window shrunk below one word");

    a_shrink_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ssw_pkg::ST_SHRINK) |=> (len_reg == $past(len_reg) - 1'b1))
        else $error("window length not reduced by a removal");

    a_found_exact: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && res.found) |-> (sum_reg == target_ext))
        else $error("found reported without an exact sum");

    a_matched_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ssw_pkg::ST_IDLE) |-> !match_reg)
        else $error("window work after a match");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ssw_pkg::ST_DROP) |=> (ovf_reg && state_reg == ssw_pkg::ST_PUSH))
        else $error("full ring drop did not flag overflow");

endmodule

>>> hdl/subarray_sum_sliding_window.sv
// top level: target register, result register and the window core
//
// channel   signals                                              direction
// elem      elem_valid/elem_ready, element_value, is_last          in
// res       res_valid/res_ready, found, start_index, end_index,    out
//           window_overflow
// cfg       cfg_wr_en, cfg_wr_data (target_sum)                   in
//
// states per element: idle, drop and push if full, check, and shrink plus check per removal
// the ring read port (one registered read a cycle) paces every removal
// elements of an array after its match are taken in idle and give no word
// reset clears the window state at once; ring contents are never read before written
// the next element is taken while a result word waits; a second result waits in the
// compare step until the first is taken
module subarray_sum_sliding_window (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              elem_valid,
    output logic                              elem_ready,
    input  logic [ssw_pkg::ELEMENT_BITS-1:0]  element_value,
    input  logic                              is_last,
    output logic                              res_valid,
    input  logic                              res_ready,
    output logic                              found,
    output logic [ssw_pkg::INDEX_BITS-1:0]    start_index,
    output logic [ssw_pkg::INDEX_BITS-1:0]    end_index,
    output logic                              window_overflow,
    input  logic                              cfg_wr_en,
    input  logic [ssw_pkg::TARGET_BITS-1:0]   cfg_wr_data
);

    logic [ssw_pkg::TARGET_BITS-1:0] target_reg, target_next;
    logic                            res_valid_reg, res_valid_next;
    ssw_pkg::result_t                res_reg, res_next;
    ssw_pkg::result_t                core_res;
    logic                            core_load;
    logic                            res_free;

    assign res_free = !res_valid_reg || res_ready;

    ssw_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .elem_valid    (elem_valid),
        .elem_ready    (elem_ready),
        .element_value (element_value),
        .is_last       (is_last),
        .target        (target_reg),
        .res_free      (res_free),
        .res_load      (core_load),
        .res           (core_res)
    );

    always_comb
    begin
        target_next    = cfg_wr_en ? cfg_wr_data : target_reg;
        res_next       = core_load ? core_res : res_reg;
        res_valid_next = core_load ? 1'b1 : (res_ready ? 1'b0 : res_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            target_reg    <= target_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid       = res_valid_reg;
    assign found           = res_reg.found;
    assign start_index     = res_reg.start_index;
    assign end_index       = res_reg.end_index;
    assign window_overflow = res_reg.window_overflow;

endmodule
